[design/fmspi_pkg.sv]
package fmspi_pkg;

	localparam int MOTOR_COUNT_DEF   = 4;
	localparam int INTEGRAL_BITS_DEF = 40;
	localparam int OUT_FIELDS        = 4;

	// item field widths
	localparam int MIDX_W   = 2;
	localparam int SPEED_W  = 16;
	localparam int STAMP_W  = 32;
	localparam int TARGET_W = 18;
	localparam int WORD_W   = 16;

	// configuration register widths
	localparam int GAIN_W      = 8;
	localparam int THR_W       = 18;
	localparam int GAP_W       = 20;
	localparam int LIM_W       = 15;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN,
		REG_THRESHOLD,
		REG_GAP_LIMIT,
		REG_OUT_LIMIT
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [THR_W-1:0]  threshold;
		logic [GAP_W-1:0]  gap_limit;
		logic [LIM_W-1:0]  out_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gain:      GAIN_W'(65),
		threshold: THR_W'(25600),
		gap_limit: GAP_W'(2000),
		out_limit: LIM_W'(10000)
	};

	// datapath widths
	localparam int VMAG_W  = 15;   // magnitude of decoded rotor speed
	localparam int SPRD_W  = 36;   // |v| times speed reciprocal
	localparam int SMAG_W  = 18;   // magnitude of shaft speed, q8
	localparam int E_W     = 20;   // speed error, signed
	localparam int W_W     = 43;   // 1000*e + clamped integral, signed
	localparam int WABS_W  = 41;
	localparam int N_W     = 49;   // gain times magnitude
	localparam int Y_W     = 22;
	localparam int DPRD_W  = 45;

	// |v|*256/36 == (|v| * SPEED_RECIP) >> SPEED_SHIFT, exact for 15-bit |v|
	localparam logic [20:0] SPEED_RECIP = 21'd1864136;
	localparam int          SPEED_SHIFT = 18;

	// floor(y/125) == (y * DIV_RECIP) >> DIV_SHIFT, exact for 22-bit y
	localparam logic [22:0] DIV_RECIP   = 23'd4294968;
	localparam int          DIV_SHIFT   = 29;
	localparam int          SMALL_SHIFT = 11;   // 256000 = 2^11 * 125
	localparam int          BIG_SHIFT   = 9;    // divide by 512

	// quotients at or above this are past any output limit
	localparam logic [WORD_W-1:0] QUOT_CAP    = 16'd32768;
	localparam logic [N_W-1:0]    SMALL_SAT_N = 49'd8388608000;

	localparam logic signed [64:0] INTEG_CAP  = 65'sd1099511627776;
	localparam logic [WORD_W-1:0]  WORD_FULL  = 16'hFFFF;
	localparam logic [SPEED_W-1:0] RAW_FULL   = 16'hFFFF;
	localparam logic signed [W_W-1:0] E_SCALE = 43'sd1000;

endpackage

[design/fmspi_if.sv]
interface fmspi_fb_if import fmspi_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [MIDX_W-1:0]          motor_index;
	logic [SPEED_W-1:0]         speed_raw;
	logic [STAMP_W-1:0]         time_us;
	logic signed [TARGET_W-1:0] target_speed;

	modport source (output valid, motor_index, speed_raw, time_us, target_speed, input ready);
	modport sink   (input valid, motor_index, speed_raw, time_us, target_speed, output ready);
endinterface

interface fmspi_drv_if import fmspi_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] drive_word_0;
	logic [WORD_W-1:0] drive_word_1;
	logic [WORD_W-1:0] drive_word_2;
	logic [WORD_W-1:0] drive_word_3;

	modport source (output valid, drive_word_0, drive_word_1, drive_word_2, drive_word_3,
		input ready);
	modport sink   (input valid, drive_word_0, drive_word_1, drive_word_2, drive_word_3,
		output ready);
endinterface

[design/fmspi_ram.sv]
module fmspi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/fmspi_cfg.sv]
module fmspi_cfg import fmspi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (we) begin
			case (cfg_reg_t'(index))
				REG_GAIN:      cfg_q.gain      <= wdata[GAIN_W-1:0];
				REG_THRESHOLD: cfg_q.threshold <= wdata[THR_W-1:0];
				REG_GAP_LIMIT: cfg_q.gap_limit <= wdata[GAP_W-1:0];
				REG_OUT_LIMIT: cfg_q.out_limit <= wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/fmspi_core.sv]
module fmspi_core import fmspi_pkg::*; #(
	parameter int MOTOR_COUNT   = MOTOR_COUNT_DEF,
	parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	fmspi_fb_if.sink    feedback,
	fmspi_drv_if.source drive
);

	localparam int AW    = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam int IB    = INTEGRAL_BITS;
	localparam int RAM_W = STAMP_W + IB;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_S1,
		ST_S2,
		ST_S3,
		ST_S4,
		ST_S5,
		ST_S6
	} state_t;

	state_t                 state_q;
	logic [MOTOR_COUNT-1:0] seen_q;
	logic [MOTOR_COUNT-1:0] vld_q;
	logic                   init_q;
	logic [WORD_W-1:0]      held_q [MOTOR_COUNT];
	logic                   out_valid_q;
	logic [WORD_W-1:0]      words_q [OUT_FIELDS];

	// item registers
	logic [STAMP_W-1:0]         time_q;
	logic signed [TARGET_W-1:0] target_q;
	logic [MIDX_W-1:0]          midx_q;
	logic                       act_q;
	logic                       upd_q;
	logic [SPRD_W-1:0]          prod_s1;
	logic                       vneg_s1;
	logic signed [E_W-1:0]      e_s2;
	logic signed [IB-1:0]       sum_s2;
	logic signed [E_W-1:0]      e_s3;
	logic [E_W-1:0]             eabs_s3;
	logic                       small_s3;
	logic signed [IB-1:0]       sum_s3;
	logic signed [W_W-1:0]      w_s4;
	logic [N_W-1:0]             n_s5;
	logic                       neg_s5;
	logic                       small_s5;
	logic [WORD_W-1:0]          q_s6;
	logic                       neg_s6;

	logic accept;
	assign feedback.ready = (state_q == ST_IDLE);
	assign accept = feedback.valid && feedback.ready;

	// decode raw word: negative half maps to raw - 65535
	logic               raw_neg;
	logic [VMAG_W-1:0]  v_mag;
	logic [SPEED_W-1:0] raw_comp;
	assign raw_neg  = feedback.speed_raw[SPEED_W-1];
	assign raw_comp = RAW_FULL - feedback.speed_raw;
	assign v_mag    = raw_neg ? raw_comp[VMAG_W-1:0] : feedback.speed_raw[VMAG_W-1:0];

	logic [MOTOR_COUNT-1:0] motor_bit;
	logic [AW-1:0]          addr;
	logic                   idx_ok;
	assign motor_bit = MOTOR_COUNT'(1) << midx_q;
	assign idx_ok    = |motor_bit;
	assign addr      = AW'(midx_q);

	logic              ram_we;
	logic [RAM_W-1:0]  ram_wdata;
	logic [RAM_W-1:0]  ram_rdata;

	fmspi_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MOTOR_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(AW'(feedback.motor_index)),
		.rdata(ram_rdata)
	);

	// s1: speed error and gap check
	logic [SMAG_W-1:0]     speed_mag;
	logic signed [E_W-1:0] speed;
	logic signed [E_W-1:0] e_now;
	logic                  rd_ok;
	logic [STAMP_W-1:0]    rd_stamp;
	logic signed [IB-1:0]  rd_sum;
	logic [STAMP_W-1:0]    gap;
	logic                  act;
	logic                  upd;

	assign speed_mag = prod_s1[SPRD_W-1:SPEED_SHIFT];
	assign speed     = vneg_s1 ? -$signed({2'b00, speed_mag}) : $signed({2'b00, speed_mag});
	assign e_now     = E_W'(target_q) - speed;
	assign rd_ok     = |(vld_q & motor_bit);
	assign rd_stamp  = rd_ok ? ram_rdata[STAMP_W-1:0] : '0;
	assign rd_sum    = rd_ok ? $signed(ram_rdata[RAM_W-1:STAMP_W]) : '0;
	assign gap       = time_q - rd_stamp;
	assign act       = idx_ok && !(|(seen_q & motor_bit));
	assign upd       = act && init_q && (gap < STAMP_W'(cfg.gap_limit));

	// s2: saturating integral update
	logic [IB:0]          sum_wide;
	logic signed [IB-1:0] sum_sat;
	logic [E_W-1:0]       e_abs;
	assign sum_wide = {sum_s2[IB-1], sum_s2} + (IB+1)'(e_s2);
	always_comb begin
		if (sum_wide[IB] != sum_wide[IB-1]) begin
			sum_sat = sum_wide[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[IB-1:0];
		end
	end
	assign e_abs = e_s2[E_W-1] ? E_W'(-e_s2) : E_W'(e_s2);

	// s3: 1000*e plus the integral capped at 2^40
	logic signed [64:0] sum_x;
	logic signed [64:0] sum_c;
	assign sum_x = 65'(sum_s3);
	always_comb begin
		if (sum_x > INTEG_CAP) begin
			sum_c = INTEG_CAP;
		end else if (sum_x < -INTEG_CAP) begin
			sum_c = -INTEG_CAP;
		end else begin
			sum_c = sum_x;
		end
	end

	// s4: gain multiply on magnitude
	logic [W_W-1:0]    w_abs;
	logic [WABS_W-1:0] mag_in;
	assign w_abs  = w_s4[W_W-1] ? W_W'(-w_s4) : W_W'(w_s4);
	assign mag_in = small_s3 ? w_abs[WABS_W-1:0] : WABS_W'(eabs_s3);

	// s5: divide by 256000 or by 512, capped past the output range
	logic [Y_W-1:0]            y_div;
	logic [DPRD_W-1:0]         dprod;
	logic [N_W-BIG_SHIFT-1:0]  t_big;
	logic [WORD_W-1:0]         q_next;
	assign y_div = n_s5[SMALL_SHIFT+Y_W-1:SMALL_SHIFT];
	assign dprod = DPRD_W'(y_div) * DPRD_W'(DIV_RECIP);
	assign t_big = n_s5[N_W-1:BIG_SHIFT];
	always_comb begin
		if (small_s5) begin
			q_next = (n_s5 >= SMALL_SAT_N) ? QUOT_CAP : dprod[DIV_SHIFT+WORD_W-1:DIV_SHIFT];
		end else begin
			q_next = (t_big >= (N_W-BIG_SHIFT)'(QUOT_CAP)) ? QUOT_CAP : t_big[WORD_W-1:0];
		end
	end

	// s6: clamp, encode, write back, round bookkeeping
	logic [LIM_W-1:0]       cmd_mag;
	logic [WORD_W-1:0]      word;
	logic [MOTOR_COUNT-1:0] seen_next;
	logic                   round_done;
	logic                   emit;
	logic                   go;
	logic [WORD_W-1:0]      next_word [OUT_FIELDS];

	assign cmd_mag    = (q_s6 > WORD_W'(cfg.out_limit)) ? cfg.out_limit : q_s6[LIM_W-1:0];
	assign word       = (neg_s6 && (cmd_mag != '0)) ? WORD_FULL - WORD_W'(cmd_mag)
		: WORD_W'(cmd_mag);
	assign seen_next  = seen_q | motor_bit;
	assign round_done = act_q && (seen_next == '1);
	assign emit       = round_done && init_q;
	assign go         = (state_q == ST_S6) && !(emit && out_valid_q && !drive.ready);
	assign ram_we     = go && act_q;
	assign ram_wdata  = {sum_s3, time_q};

	for (genvar j = 0; j < OUT_FIELDS; j++) begin : g_word
		if (j < MOTOR_COUNT) begin : g_live
			assign next_word[j] = (upd_q && (addr == AW'(j))) ? word : held_q[j];
		end else begin : g_none
			assign next_word[j] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= '0;
			vld_q       <= '0;
			init_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				held_q[i] <= '0;
			end
			for (int i = 0; i < OUT_FIELDS; i++) begin
				words_q[i] <= '0;
			end
		end else begin
			// a new item loaded in the same cycle keeps valid high
			if (out_valid_q && drive.ready && !(go && emit)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_S1;
				ST_S1:   state_q <= ST_S2;
				ST_S2:   state_q <= ST_S3;
				ST_S3:   state_q <= ST_S4;
				ST_S4:   state_q <= ST_S5;
				ST_S5:   state_q <= ST_S6;
				ST_S6: begin
					if (go) begin
						state_q <= ST_IDLE;
						if (act_q) begin
							vld_q <= vld_q | motor_bit;
							seen_q <= round_done ? '0 : seen_next;
							if (round_done) begin
								init_q <= 1'b1;
							end
						end
						if (upd_q) begin
							held_q[addr] <= word;
						end
						if (emit) begin
							out_valid_q <= 1'b1;
							for (int i = 0; i < OUT_FIELDS; i++) begin
								words_q[i] <= next_word[i];
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			time_q   <= feedback.time_us;
			target_q <= feedback.target_speed;
			midx_q   <= feedback.motor_index;
			prod_s1  <= SPRD_W'(v_mag) * SPRD_W'(SPEED_RECIP);
			vneg_s1  <= raw_neg;
		end
		case (state_q)
			ST_S1: begin
				e_s2   <= e_now;
				sum_s2 <= rd_sum;
				act_q  <= act;
				upd_q  <= upd;
			end
			ST_S2: begin
				sum_s3   <= upd_q ? sum_sat : sum_s2;
				e_s3     <= e_s2;
				eabs_s3  <= e_abs;
				small_s3 <= e_abs < E_W'(cfg.threshold);
			end
			ST_S3: begin
				w_s4 <= W_W'(sum_c) + W_W'(e_s3) * E_SCALE;
			end
			ST_S4: begin
				n_s5     <= N_W'(cfg.gain) * N_W'(mag_in);
				neg_s5   <= small_s3 ? w_s4[W_W-1] : e_s3[E_W-1];
				small_s5 <= small_s3;
			end
			ST_S5: begin
				q_s6   <= q_next;
				neg_s6 <= neg_s5;
			end
			default: ;
		endcase
	end

	assign drive.valid        = out_valid_q;
	assign drive.drive_word_0 = words_q[0];
	assign drive.drive_word_1 = words_q[1];
	assign drive.drive_word_2 = words_q[2];
	assign drive.drive_word_3 = words_q[3];

	a_emit_ends_round: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_S6) && init_q && (seen_q == '0))
		else $error("drive item raised outside a completed round");

	a_init_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |=> init_q)
		else $error("init flag dropped");

	a_update_after_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_S6 && upd_q) |-> (init_q && act_q))
		else $error("controller update during startup round or ignored frame");

	a_no_emit_startup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_S6 && !init_q) |=> !$rose(out_valid_q))
		else $error("drive item emitted by startup round");

endmodule

[design/four_motor_speed_pi_controller_top.sv]
// output: a drive item is registered when the feedback item that completes a round leaves S6
// input: one feedback item at a time; the single-item sequencer is idle again only after it walks
//   state ram read, error, integral update, gain multiply, reciprocal divide and write-back
// reset: asynchronous, clears the sequencer, round mask and held commands, loads register
//   defaults; per-motor valid flags make the state ram read as zero until first written
module four_motor_speed_pi_controller_top import fmspi_pkg::*; #(
	parameter int MOTOR_COUNT   = MOTOR_COUNT_DEF,
	parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	fmspi_fb_if.sink              feedback,
	fmspi_drv_if.source           drive
);

	cfg_t cfg;

	fmspi_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.index (cfg_index),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	fmspi_core #(
		.MOTOR_COUNT  (MOTOR_COUNT),
		.INTEGRAL_BITS(INTEGRAL_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.feedback(feedback),
		.drive   (drive)
	);

endmodule
